/* design/stq_pkg.sv */
package stq_pkg;

  localparam int unsigned TimerSlots = 32;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned IdxW       = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam logic [31:0] FarDeadline = 32'hffff_ffff;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_BIND  = 3'd2,
    CMD_ARM   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_EXPIRE = 2'd1,
    KIND_TASK   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_st_e;

  // One queue entry: a running timer in deadline order.
  typedef struct packed {
    logic              vld;
    logic [SlotW-1:0]  slot;
    logic [31:0]       deadline;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              ins;      // insert new entry at sorted place
    logic              pop;      // shift whole row one step toward head
    logic [SlotW-1:0]  slot;
    logic [31:0]       deadline;
  } cell_ctl_t;

endpackage

/* design/sorted_timer_queue.sv */
// Pool of TimerSlots software timers. Running timers sit in a row of cells
// sorted by absolute deadline, head in cell 0; an arm inserts by shifting
// the later entries one cell toward the tail, and each due timer at a tick
// pops the head. Allocate, free, bind and arm run from the registered
// request and give their result in the output register, after which the
// next request can be taken. A tick advances the time, pops each due timer
// in turn with an expiry result for each but the task timer, then gives a
// task-switch result if the task timer expired; a stalled sink holds these
// steps. Slot 0 is the sentinel; it is never stored in the
// row: an empty row means the sentinel (deadline all ones) is next due, and
// it never expires. Results wait in an output register; the next request is
// taken once the current one has registered its last result. Destination and
// data words per slot are held in registers indexed by slot number and are
// undefined until bound.
module sorted_timer_queue
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  slot_i,
  input  logic [31:0] timeout_i,
  input  logic [7:0]  dest_i,
  input  logic [31:0] payload_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  out_slot_o,
  output logic [7:0]  out_dest_o,
  output logic [31:0] out_payload_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_TASK = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [5:0]  task_q;
  logic [31:0] tick_q, tick_d;
  logic [2:0]  cmd_q;
  logic [5:0]  slot_q;
  logic [31:0] tmo_q;
  logic        ts_q, ts_d;

  logic [1:0]  st_q [TimerSlots];
  logic [7:0]  dest_q [TimerSlots];
  logic [31:0] pay_q [TimerSlots];

  entry_t    row [TimerSlots+1];
  entry_t    zero_ent;
  cell_ctl_t ctl;

  // output register
  logic        ov_q;
  logic [1:0]  kind_q;
  logic [5:0]  oslot_q;
  logic [7:0]  odest_q;
  logic [31:0] opay_q;
  logic        last_q;
  logic        out_free;

  logic        emit;
  logic [1:0]  e_kind;
  logic [5:0]  e_slot;
  logic [7:0]  e_dest;
  logic [31:0] e_pay;
  logic        e_last;

  logic [IdxW-1:0] free_idx;
  logic            free_found;
  logic            in_range;
  logic [IdxW-1:0] sidx;
  logic [IdxW-1:0] hidx;
  logic            head_due;
  logic            slot_free_we, slot_alloc_we, slot_run_we, head_alloc_we;
  logic [IdxW-1:0] alloc_idx;

  assign zero_ent = '0;
  assign row[TimerSlots] = zero_ent;

  for (genvar g = 0; g < TimerSlots; g++) begin : g_cell
    stq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .head_i (g == 0),
      .ctl_i  (ctl),
      .left_i ((g == 0) ? zero_ent : row[(g == 0) ? 0 : g-1]),
      .right_i(row[g+1]),
      .ent_o  (row[g])
    );
  end

  // output register can take a new result when empty or being drained
  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign in_range = ({26'd0, slot_q} < TimerSlots);
  assign sidx     = slot_q[IdxW-1:0];
  assign hidx     = row[0].slot[IdxW-1:0];
  assign head_due = row[0].vld && (row[0].deadline <= tick_q);

  // first free slot, priority search
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TimerSlots-1; i >= 0; i--) begin
      if (st_q[i] == ST_FREE) begin
        free_idx   = IdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    tick_d        = tick_q;
    ts_d          = ts_q;
    ctl           = '0;
    ctl.slot      = slot_q;
    ctl.deadline  = tmo_q + tick_q;
    emit          = 1'b0;
    e_kind        = KIND_ACK;
    e_slot        = slot_q;
    e_dest        = '0;
    e_pay         = '0;
    e_last        = 1'b1;
    slot_free_we  = 1'b0;
    slot_alloc_we = 1'b0;
    slot_run_we   = 1'b0;
    head_alloc_we = 1'b0;
    alloc_idx     = free_idx;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          emit    = 1'b1;
          case (cmd_q) inside
            CMD_ALLOC: begin
              if (free_found) begin
                slot_alloc_we = 1'b1;
                e_slot        = 6'(free_idx);
              end else begin
                e_kind = KIND_ERROR;
                e_slot = '0;
              end
            end
            CMD_FREE, CMD_ARM: begin
              if (!in_range || st_q[sidx] == ST_RUN) begin
                e_kind = KIND_ERROR;
              end else if (cmd_q == CMD_FREE) begin
                slot_free_we = 1'b1;
              end else begin
                slot_run_we = 1'b1;
                ctl.ins     = 1'b1;
              end
            end
            CMD_BIND: begin
              if (!in_range) begin
                e_kind = KIND_ERROR;
              end
            end
            CMD_TICK: begin
              emit    = 1'b0;
              tick_d  = tick_q + 32'd1;
              ts_d    = 1'b0;
              state_d = S_POP;
            end
            default: begin
              e_kind = KIND_ERROR;
              e_slot = '0;
            end
          endcase
        end
      end
      S_POP: begin
        if (head_due) begin
          if (row[0].slot == task_q) begin
            ts_d          = 1'b1;
            head_alloc_we = 1'b1;
            ctl.pop       = 1'b1;
          end else if (out_free) begin
            head_alloc_we = 1'b1;
            ctl.pop       = 1'b1;
            emit          = 1'b1;
            e_kind        = KIND_EXPIRE;
            e_slot        = row[0].slot;
            e_dest        = dest_q[hidx];
            e_pay         = pay_q[hidx];
            // last unless more due or a task switch follows
            e_last        = !(row[1].vld && row[1].deadline <= tick_q) && !ts_q;
          end
        end else begin
          state_d = ts_q ? S_TASK : S_IDLE;
        end
      end
      S_TASK: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = KIND_TASK;
          e_slot  = task_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tick_q  <= '0;
      ts_q    <= 1'b0;
      task_q  <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < TimerSlots; i++) begin
        st_q[i] <= (i == 0) ? ST_RUN : ST_FREE;
      end
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      ts_q    <= ts_d;
      if (cfg_valid_i) begin
        task_q <= cfg_data_i;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (slot_alloc_we) st_q[alloc_idx] <= ST_ALLOC;
      if (slot_free_we)  st_q[sidx]      <= ST_FREE;
      if (slot_run_we)   st_q[sidx]      <= ST_RUN;
      if (head_alloc_we) st_q[hidx]      <= ST_ALLOC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      tmo_q  <= timeout_i;
      if (cmd_i == CMD_BIND && {26'd0, slot_i} < TimerSlots) begin
        dest_q[slot_i[IdxW-1:0]] <= dest_i;
        pay_q[slot_i[IdxW-1:0]]  <= payload_i;
      end
    end
    if (emit) begin
      kind_q  <= e_kind;
      oslot_q <= e_slot;
      odest_q <= e_dest;
      opay_q  <= e_pay;
      last_q  <= e_last;
    end
  end

  // Tick with last expiry popped while a task switch is pending: the task
  // result carries last, so expiry results never do in that case.
  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign out_slot_o    = oslot_q;
  assign out_dest_o    = odest_q;
  assign out_payload_o = opay_q;
  assign last_o        = last_q;

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !ov_q || out_ready_i)
    else $error("result overwritten");

  // Head of the row is never a free slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row[0].vld |-> st_q[hidx] == ST_RUN || st_q[hidx] == ST_ALLOC)
    else $error("free slot in queue");

  // Sentinel stays running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q[0] == ST_RUN)
    else $error("sentinel lost");

endmodule

/* design/stq_cell.sv */
module stq_cell
  import stq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_i,    // cell at the head of the row
  input  cell_ctl_t ctl_i,
  input  entry_t    left_i,    // neighbor toward head
  input  entry_t    right_i,   // neighbor toward tail
  output entry_t    ent_o
);

  entry_t ent_q, ent_d;
  logic   here_before, left_before;

  // New entry goes ahead of entries with equal deadline.
  // Nothing sits left of the head cell, so it never shifts in from there.
  assign here_before = !ent_q.vld || (ctl_i.deadline <= ent_q.deadline);
  assign left_before = !head_i &&
                       (!left_i.vld || (ctl_i.deadline <= left_i.deadline));

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.pop) begin
      ent_d = right_i;
    end else if (ctl_i.ins && here_before) begin
      if (left_before) begin
        ent_d = left_i;
      end else begin
        ent_d.vld      = 1'b1;
        ent_d.slot     = ctl_i.slot;
        ent_d.deadline = ctl_i.deadline;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule
